FILE: rtl/segalloc_pkg.sv
// ----------------------------------------------------------------------------
// Segment allocator package
// Shared widths, codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package segalloc_pkg;

	localparam int ADDR_BITS        = 20;
	localparam int LEN_W            = ADDR_BITS + 1;
	localparam int OWNER_W          = 31;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam logic [LEN_W-1:0]   MEM_CAP = LEN_W'(1) << ADDR_BITS;
	localparam logic [OWNER_W-1:0] OWNER_FIRST = OWNER_W'(1);

	// operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// placement rules (any other code acts as first fit)
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_BADID = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// register indexes
	localparam logic [0:0] REG_MEM_SIZE   = 1'b0;
	localparam logic [0:0] REG_FIT_POLICY = 1'b1;

	typedef struct packed {
		logic                 used;
		logic [OWNER_W-1:0]   owner;
		logic [LEN_W-1:0]     len;
		logic [ADDR_BITS-1:0] start;
	} entry_t;

	typedef struct packed {
		logic idle;
		logic accept;
		logic scan;
		logic decide;
		logic shift;
		logic tail;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic init_pending;
		logic walk_done;
		logic need_tail;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/segment_allocator_fit_policy_core.sv
// ----------------------------------------------------------------------------
// Segment allocator core
// Address-ordered segment table with first/best/worst fit and coalescing.
// ----------------------------------------------------------------------------
// Steps: table scan, decision, table shift, tail write on a split, result.
// Throughput: one item at a time; input stalls until the result is loaded,
//   set by the single-port walk of the segment table memory.
// Reset: one free segment of 1048576 bytes, first fit, first id 1; the table
//   is rebuilt after reset and after each memory_size write.
module segment_allocator_fit_policy_core #(
	parameter int MAX_SEGMENTS = segalloc_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  operation,
	input  logic [segalloc_pkg::LEN_W-1:0]        request_size,
	input  logic [segalloc_pkg::OWNER_W-1:0]      block_id,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic [segalloc_pkg::OWNER_W-1:0]      granted_id,
	output logic [segalloc_pkg::ADDR_BITS-1:0]    granted_address,
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_index,
	input  logic [segalloc_pkg::LEN_W-1:0]        cfg_wdata
);

	segalloc_pkg::cmd_t cmd;
	segalloc_pkg::sts_t sts;

	segalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	segalloc_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.request_size    (request_size),
		.block_id        (block_id),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.status          (status),
		.granted_id      (granted_id),
		.granted_address (granted_address)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a beat is in work");

	a_rebuild_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sts.init_pending |-> in_stall)
		else $error("input open during table rebuild");

	a_decide_then_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> cmd.shift)
		else $error("decision not followed by table shift");

	a_respond_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.respond && sts.out_free) |=> out_valid)
		else $error("result beat lost");

endmodule

FILE: rtl/segalloc_ctrl.sv
// ----------------------------------------------------------------------------
// Segment allocator controller
// Sequences scan, decision, table shift, tail write and response.
// ----------------------------------------------------------------------------
module segalloc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  segalloc_pkg::sts_t  sts,
	output segalloc_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_TAIL,
		S_RESP
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE) || sts.init_pending;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd         = '0;
		cmd.idle    = (state_q == S_IDLE);
		cmd.accept  = accept;
		cmd.scan    = (state_q == S_SCAN);
		cmd.decide  = (state_q == S_DECIDE);
		cmd.shift   = (state_q == S_SHIFT);
		cmd.tail    = (state_q == S_TAIL);
		cmd.respond = (state_q == S_RESP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.walk_done) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (sts.walk_done) state_q <= sts.need_tail ? S_TAIL : S_RESP;
				end
				S_TAIL: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/segalloc_dp.sv
// ----------------------------------------------------------------------------
// Segment allocator datapath
// Segment table memory, scan trackers, shift walker, registers and result.
// ----------------------------------------------------------------------------
module segalloc_dp #(
	parameter int MAX_SEGMENTS = segalloc_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  segalloc_pkg::cmd_t                    cmd,
	output segalloc_pkg::sts_t                    sts,
	input  logic                                  operation,
	input  logic [segalloc_pkg::LEN_W-1:0]        request_size,
	input  logic [segalloc_pkg::OWNER_W-1:0]      block_id,
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_index,
	input  logic [segalloc_pkg::LEN_W-1:0]        cfg_wdata,
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output logic [1:0]                            status,
	output logic [segalloc_pkg::OWNER_W-1:0]      granted_id,
	output logic [segalloc_pkg::ADDR_BITS-1:0]    granted_address
);

	localparam int IW    = $clog2(MAX_SEGMENTS);
	localparam int CW    = $clog2(MAX_SEGMENTS + 1);
	localparam int LEN_W = segalloc_pkg::LEN_W;
	localparam int OW    = segalloc_pkg::OWNER_W;
	localparam int AW    = segalloc_pkg::ADDR_BITS;

	segalloc_pkg::entry_t mem [MAX_SEGMENTS];
	segalloc_pkg::entry_t rd_q;
	segalloc_pkg::entry_t wr_data;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;

	// configuration and table state
	logic [LEN_W-1:0] mem_size_q;
	logic [1:0]       policy_q;
	logic [CW-1:0]    count_q;
	logic [OW-1:0]    next_owner_q;
	logic             init_pending_q;

	// request
	logic             op_q;
	logic [LEN_W-1:0] size_q;
	logic [OW-1:0]    id_q;

	// table walker
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] left_q;
	logic          walk_desc_q;
	logic          pend_q;
	logic [IW-1:0] pend_idx_q;
	logic [1:0]    dist_q;
	logic          split_q;

	// scan trackers
	logic                 found_q;
	logic [IW-1:0]        best_idx_q;
	logic [LEN_W-1:0]     best_len_q;
	logic [AW-1:0]        best_start_q;
	segalloc_pkg::entry_t last_q;
	logic                 have_last_q;
	segalloc_pkg::entry_t prev_q;
	logic                 prev_free_q;
	logic                 want_nxt_q;
	segalloc_pkg::entry_t nxt_q;
	logic                 have_nxt_q;

	// result staging and output
	logic [1:0]    res_status_q;
	logic [OW-1:0] res_id_q;
	logic [AW-1:0] res_addr_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [OW-1:0] granted_id_q;
	logic [AW-1:0] granted_address_q;

	logic             fits;
	logic             better;
	logic             take_alloc;
	logic             hit_free;
	logic             exact;
	logic             alloc_ok;
	logic             nxt_free;
	logic [CW-1:0]    src0;
	logic [IW-1:0]    tgt_idx;
	logic [AW-1:0]    tgt_start;
	logic [LEN_W-1:0] tgt_len;
	logic [LEN_W-1:0] cfg_size;
	logic             out_free;

	// ---------------------------------------------------------------- memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[ptr_q];
	end

	// ------------------------------------------------------------ scan logic
	always_comb begin
		fits = !rd_q.used && (rd_q.len >= size_q) && (size_q != '0);
		case (policy_q)
			segalloc_pkg::POL_BEST:  better = rd_q.len < best_len_q;
			segalloc_pkg::POL_WORST: better = rd_q.len > best_len_q;
			default:                 better = 1'b0;
		endcase
		take_alloc = fits && (!found_q || better);
		hit_free   = rd_q.used && (rd_q.owner == id_q) && !found_q;
	end

	// --------------------------------------------------------- decision logic
	always_comb begin
		exact     = (best_len_q == size_q);
		alloc_ok  = found_q && (exact || (count_q != CW'(MAX_SEGMENTS)));
		nxt_free  = have_nxt_q && !nxt_q.used;
		src0      = CW'(best_idx_q) + CW'(1) + CW'(nxt_free);
		tgt_idx   = prev_free_q ? (best_idx_q - IW'(1)) : best_idx_q;
		tgt_start = prev_free_q ? prev_q.start : best_start_q;
		tgt_len   = LEN_W'((prev_free_q ? prev_q.len : LEN_W'(0)) + best_len_q
			+ (nxt_free ? nxt_q.len : LEN_W'(0)));
	end

	always_comb begin
		cfg_size = cfg_wdata;
		if (cfg_size == '0) cfg_size = LEN_W'(1);
		else if (cfg_size > segalloc_pkg::MEM_CAP) cfg_size = segalloc_pkg::MEM_CAP;
	end

	// ------------------------------------------------------------ write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.idle && init_pending_q) begin
			wr_en       = 1'b1;
			wr_data.len = mem_size_q;
		end else if (cmd.decide) begin
			if (op_q == segalloc_pkg::OP_ALLOC) begin
				wr_en         = alloc_ok;
				wr_addr       = best_idx_q;
				wr_data.used  = 1'b1;
				wr_data.owner = next_owner_q;
				wr_data.len   = size_q;
				wr_data.start = best_start_q;
			end else begin
				wr_en         = found_q;
				wr_addr       = tgt_idx;
				wr_data.len   = tgt_len;
				wr_data.start = tgt_start;
			end
		end else if (cmd.shift && pend_q) begin
			wr_en   = 1'b1;
			wr_addr = walk_desc_q ? (pend_idx_q + IW'(1))
				: IW'(CW'(pend_idx_q) - CW'(dist_q));
			wr_data = rd_q;
		end else if (cmd.tail) begin
			wr_en         = 1'b1;
			wr_addr       = best_idx_q + IW'(1);
			wr_data.len   = best_len_q - size_q;
			wr_data.start = best_start_q + size_q[AW-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts              = '0;
		sts.init_pending = init_pending_q;
		sts.walk_done    = (left_q == '0) && !pend_q;
		sts.need_tail    = split_q;
		sts.out_free     = out_free;
	end

	// ------------------------------------------------------ request payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			size_q <= request_size;
			id_q   <= block_id;
		end
	end

	// ------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q     <= segalloc_pkg::MEM_CAP;
			policy_q       <= segalloc_pkg::POL_FIRST;
			count_q        <= CW'(1);
			next_owner_q   <= segalloc_pkg::OWNER_FIRST;
			init_pending_q <= 1'b1;
			ptr_q          <= '0;
			left_q         <= '0;
			walk_desc_q    <= 1'b0;
			pend_q         <= 1'b0;
			pend_idx_q     <= '0;
			dist_q         <= '0;
			split_q        <= 1'b0;
			found_q        <= 1'b0;
			best_idx_q     <= '0;
			best_len_q     <= '0;
			best_start_q   <= '0;
			last_q         <= '0;
			have_last_q    <= 1'b0;
			prev_q         <= '0;
			prev_free_q    <= 1'b0;
			want_nxt_q     <= 1'b0;
			nxt_q          <= '0;
			have_nxt_q     <= 1'b0;
			res_status_q   <= segalloc_pkg::ST_OK;
			res_id_q       <= '0;
			res_addr_q     <= '0;
		end else begin
			// drop the pending table rebuild once entry 0 is written
			if (cmd.idle && init_pending_q) init_pending_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					segalloc_pkg::REG_MEM_SIZE: begin
						mem_size_q     <= cfg_size;
						count_q        <= CW'(1);
						init_pending_q <= 1'b1;
					end
					segalloc_pkg::REG_FIT_POLICY: policy_q <= cfg_wdata[1:0];
					default: ;
				endcase
			end

			if (cmd.accept) begin
				ptr_q       <= '0;
				left_q      <= count_q;
				walk_desc_q <= 1'b0;
				pend_q      <= 1'b0;
				split_q     <= 1'b0;
				found_q     <= 1'b0;
				have_last_q <= 1'b0;
				prev_free_q <= 1'b0;
				want_nxt_q  <= 1'b0;
				have_nxt_q  <= 1'b0;
			end

			// advance the walker: one read a cycle, its data checked in the next cycle
			if (cmd.scan || cmd.shift) begin
				if (left_q != '0) begin
					ptr_q      <= walk_desc_q ? (ptr_q - IW'(1)) : (ptr_q + IW'(1));
					left_q     <= left_q - CW'(1);
					pend_q     <= 1'b1;
					pend_idx_q <= ptr_q;
				end else begin
					pend_q <= 1'b0;
				end
			end

			if (cmd.scan && pend_q) begin
				last_q      <= rd_q;
				have_last_q <= 1'b1;
				if (want_nxt_q) begin
					nxt_q      <= rd_q;
					have_nxt_q <= 1'b1;
					want_nxt_q <= 1'b0;
				end
				if (op_q == segalloc_pkg::OP_ALLOC) begin
					if (take_alloc) begin
						found_q      <= 1'b1;
						best_idx_q   <= pend_idx_q;
						best_len_q   <= rd_q.len;
						best_start_q <= rd_q.start;
					end
				end else if (hit_free) begin
					found_q      <= 1'b1;
					best_idx_q   <= pend_idx_q;
					best_len_q   <= rd_q.len;
					best_start_q <= rd_q.start;
					prev_q       <= last_q;
					prev_free_q  <= have_last_q && !last_q.used;
					want_nxt_q   <= 1'b1;
				end
			end

			if (cmd.decide) begin
				pend_q   <= 1'b0;
				left_q   <= '0;
				res_id_q   <= '0;
				res_addr_q <= '0;
				if (op_q == segalloc_pkg::OP_ALLOC) begin
					if (!found_q) begin
						res_status_q <= segalloc_pkg::ST_NOFIT;
					end else if (!alloc_ok) begin
						res_status_q <= segalloc_pkg::ST_FULL;
					end else begin
						res_status_q <= segalloc_pkg::ST_OK;
						res_id_q     <= next_owner_q;
						res_addr_q   <= best_start_q;
						next_owner_q <= (next_owner_q == '1) ? segalloc_pkg::OWNER_FIRST
							: (next_owner_q + OW'(1));
						if (!exact) begin
							// open a gap after the chosen entry for the remainder
							split_q     <= 1'b1;
							walk_desc_q <= 1'b1;
							ptr_q       <= IW'(count_q - CW'(1));
							left_q      <= count_q - CW'(1) - CW'(best_idx_q);
							count_q     <= count_q + CW'(1);
						end
					end
				end else if (!found_q) begin
					res_status_q <= segalloc_pkg::ST_BADID;
				end else begin
					res_status_q <= segalloc_pkg::ST_OK;
					// close up the entries swallowed by the merge
					dist_q      <= 2'(prev_free_q) + 2'(nxt_free);
					walk_desc_q <= 1'b0;
					ptr_q       <= src0[IW-1:0];
					left_q      <= count_q - src0;
					count_q     <= count_q - CW'(prev_free_q) - CW'(nxt_free);
				end
			end
		end
	end

	// ---------------------------------------------------------- result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.respond && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond && out_free) begin
			status_q          <= res_status_q;
			granted_id_q      <= res_id_q;
			granted_address_q <= res_addr_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_id      = granted_id_q;
	assign granted_address = granted_address_q;

endmodule
